// ===== rtl/core/rational_arithmetic_unit_macros.svh =====
// ----------------------------------------------------------------------------
// rational arithmetic unit assertion macros
// property wrappers for the core modules, used by rau_ctrl
// ----------------------------------------------------------------------------
`ifndef RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define RAU_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rau assertion failed");

// next-cycle implication, disabled while reset is held
`define RAU_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rau assertion failed");

`endif

// ===== rtl/core/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// rau_pkg
// shared widths, command codes, datapath ops and controller states
// ----------------------------------------------------------------------------
`default_nettype none

package rau_pkg;

    localparam int DATA_W    = 64;
    localparam int HALF_W    = DATA_W / 2;
    localparam int CMD_W     = 3;
    localparam int CNT_W     = $clog2(DATA_W);
    localparam int S_TDATA_W = 264;
    localparam int M_TDATA_W = 3 * DATA_W;

    localparam logic [CMD_W-1:0] CMD_ADD   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SUB   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MUL   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DIV   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CMP   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_RECIP = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SIMP  = 3'd6;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_MKPOS,
        OP_GCD_X1,
        OP_GCD_X2,
        OP_GCD_T,
        OP_DIV_RN,
        OP_DIV_SD,
        OP_DIV_RD,
        OP_DIV_SN,
        OP_DIV_TN,
        OP_DIV_TD,
        OP_MUL_RN_SD,
        OP_MUL_SN_RD,
        OP_MUL_RD_SD,
        OP_MUL_RN_SN,
        OP_SUM,
        OP_DIFF,
        OP_POS_T,
        OP_NAN,
        OP_EMIT
    } dp_op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_CHECK,
        ST_EMIT,
        ST_MKPOS,
        ST_GCD_X1,
        ST_DIV_RN,
        ST_DIV_SD,
        ST_GCD_X2,
        ST_DIV_RD,
        ST_DIV_SN,
        ST_MUL_RN_SN,
        ST_MUL_RD_SD,
        ST_MUL_RN_SD,
        ST_MUL_SN_RD,
        ST_SUM,
        ST_DIFF,
        ST_POS_T,
        ST_GCD_T,
        ST_DIV_TN,
        ST_DIV_TD,
        ST_NAN
    } ctrl_state_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic             done;
        logic             nan_in;
        logic             td_zero;
        logic             out_free;
        logic [CMD_W-1:0] cmd;
    } dp_stat_t;

    function automatic logic [DATA_W-1:0] mag_of(input logic [DATA_W-1:0] v);
        return v[DATA_W-1] ? ({DATA_W{1'b0}} - v) : v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rational_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// signed 64-bit fraction arithmetic with gcd reduction
// ----------------------------------------------------------------------------
//
//   channel   dir   beat contents
//   s_*       in    command, a_numerator, a_denominator, b_numerator, b_denominator
//   m_*       out   result_numerator, result_denominator, compare_value; is_nan
//
// one operation at a time; reciprocal and nan beats are the quickest and a
// multiply/divide beat the slowest, set by the binary gcd unit and the bit-serial
// divider (up to six quotients); add is quicker than multiply/divide
// a new beat is taken while a finished result still waits in the output register
// reset is synchronous, active low, and returns the sequencer to idle
//
`default_nettype none

module rational_arithmetic_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // command[2:0], a_numerator[66:3], a_denominator[130:67],
    // b_numerator[194:131], b_denominator[258:195], zero fill above
    input  wire logic [rau_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // result_numerator[63:0], result_denominator[127:64], compare_value[191:128]
    output logic [rau_pkg::M_TDATA_W-1:0]      m_tdata,
    // is_nan[0]
    output logic [0:0]                         m_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready
);

    // sequencer-to-datapath op code and status back
    rau_pkg::dp_cmd_t  dp_cmd;
    rau_pkg::dp_stat_t dp_stat;

    // controller: one state per datapath step, waits on unit completion
    rau_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (dp_cmd),
        .stat     (dp_stat)
    );

    // datapath: operand registers, shared multiplier, divider and gcd unit
    rau_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (dp_cmd),
        .stat     (dp_stat),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

// ===== rtl/core/rau_mul.sv =====
// ----------------------------------------------------------------------------
// rau_mul
// low half of a 64x64 product from three 32x32 partial products
// ----------------------------------------------------------------------------
`default_nettype none

module rau_mul (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [rau_pkg::DATA_W-1:0] op_a,
    input  wire logic [rau_pkg::DATA_W-1:0] op_b,
    output logic                            done,
    output logic [rau_pkg::DATA_W-1:0]      prod
);

    logic [rau_pkg::DATA_W-1:0] x_reg, y_reg, part_reg, acc_reg;
    logic [1:0]                 cnt_reg;
    logic                       run_reg, done_reg;
    logic [rau_pkg::HALF_W-1:0] mop_a, mop_b;
    logic [rau_pkg::DATA_W-1:0] part_next;

    // partial product order: lo*lo, lo(x)*hi(y), hi(x)*lo(y)
    assign mop_a     = (cnt_reg == 2'd2) ? x_reg[rau_pkg::DATA_W-1:rau_pkg::HALF_W]
                                         : x_reg[rau_pkg::HALF_W-1:0];
    assign mop_b     = (cnt_reg == 2'd1) ? y_reg[rau_pkg::DATA_W-1:rau_pkg::HALF_W]
                                         : y_reg[rau_pkg::HALF_W-1:0];
    assign part_next = rau_pkg::DATA_W'(mop_a) * rau_pkg::DATA_W'(mop_b);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                x_reg   <= op_a;
                y_reg   <= op_b;
                cnt_reg <= 2'd0;
                run_reg <= 1'b1;
            end else if (run_reg) begin
                cnt_reg  <= cnt_reg + 2'd1;
                part_reg <= part_next;
                case (cnt_reg)
                    2'd0: acc_reg <= acc_reg;
                    2'd1: acc_reg <= part_reg;
                    default: begin
                        acc_reg <= acc_reg + {part_reg[rau_pkg::HALF_W-1:0],
                                              {rau_pkg::HALF_W{1'b0}}};
                    end
                endcase
                if (cnt_reg == 2'd3) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

`default_nettype wire

// ===== rtl/core/rau_div.sv =====
// ----------------------------------------------------------------------------
// rau_div
// bit-serial restoring divider, signed value by unsigned magnitude
// ----------------------------------------------------------------------------
`default_nettype none

module rau_div (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [rau_pkg::DATA_W-1:0] value,
    input  wire logic [rau_pkg::DATA_W-1:0] divisor,
    output logic                            done,
    output logic [rau_pkg::DATA_W-1:0]      quot
);

    logic [rau_pkg::DATA_W-1:0] q_reg, rem_reg, den_reg;
    logic                       neg_reg, run_reg, done_reg;
    logic [rau_pkg::CNT_W-1:0]  cnt_reg;
    logic [rau_pkg::DATA_W:0]   shifted, diff;
    logic                       fits;

    assign shifted = {rem_reg, q_reg[rau_pkg::DATA_W-1]};
    assign diff    = shifted - {1'b0, den_reg};
    assign fits    = !diff[rau_pkg::DATA_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                q_reg   <= rau_pkg::mag_of(value);
                neg_reg <= value[rau_pkg::DATA_W-1];
                den_reg <= divisor;
                rem_reg <= '0;
                cnt_reg <= '0;
                run_reg <= 1'b1;
            end else if (run_reg) begin
                rem_reg <= fits ? diff[rau_pkg::DATA_W-1:0] : shifted[rau_pkg::DATA_W-1:0];
                q_reg   <= {q_reg[rau_pkg::DATA_W-2:0], fits};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == rau_pkg::CNT_W'(rau_pkg::DATA_W - 1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = neg_reg ? ({rau_pkg::DATA_W{1'b0}} - q_reg) : q_reg;

endmodule

`default_nettype wire

// ===== rtl/core/rau_gcd.sv =====
// ----------------------------------------------------------------------------
// rau_gcd
// binary gcd of two magnitudes, one step per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module rau_gcd (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [rau_pkg::DATA_W-1:0] mag_x,
    input  wire logic [rau_pkg::DATA_W-1:0] mag_y,
    output logic                            done,
    output logic [rau_pkg::DATA_W-1:0]      gcd
);

    logic [rau_pkg::DATA_W-1:0] x_reg, y_reg, g_reg;
    logic [rau_pkg::CNT_W-1:0]  k_reg;
    logic                       run_reg, done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                x_reg   <= mag_x;
                y_reg   <= mag_y;
                k_reg   <= '0;
                run_reg <= 1'b1;
            end else if (run_reg) begin
                if (x_reg == '0 || y_reg == '0) begin
                    g_reg    <= ((x_reg == '0) ? y_reg : x_reg) << k_reg;
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end else if (!x_reg[0] && !y_reg[0]) begin
                    x_reg <= x_reg >> 1;
                    y_reg <= y_reg >> 1;
                    k_reg <= k_reg + 1'b1;
                end else if (!x_reg[0]) begin
                    x_reg <= x_reg >> 1;
                end else if (!y_reg[0]) begin
                    y_reg <= y_reg >> 1;
                end else if (x_reg >= y_reg) begin
                    x_reg <= (x_reg - y_reg) >> 1;
                end else begin
                    y_reg <= (y_reg - x_reg) >> 1;
                end
            end
        end
    end

    assign done = done_reg;
    assign gcd  = g_reg;

endmodule

`default_nettype wire

// ===== rtl/core/rau_datapath.sv =====
// ----------------------------------------------------------------------------
// rau_datapath
// operand registers, multiplier, divider, gcd unit and output register
// ----------------------------------------------------------------------------
`default_nettype none

module rau_datapath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire rau_pkg::dp_cmd_t              cmd,
    output rau_pkg::dp_stat_t                  stat,
    input  wire logic [rau_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [rau_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic [0:0]                         m_tuser
);

    localparam int W = rau_pkg::DATA_W;

    logic [rau_pkg::CMD_W-1:0] cmd_reg;
    logic [W-1:0] rn_reg, rd_reg, sn_reg, sd_reg, tn_reg, td_reg, pb_reg, cmp_reg, g_reg;
    logic [W-1:0] out_n_reg, out_d_reg, out_c_reg;
    logic         nan_reg, out_nan_reg, out_valid_reg, done_reg;
    rau_pkg::dp_op_t cur_op_reg;

    logic [rau_pkg::CMD_W-1:0] in_cmd;
    logic [W-1:0] in_an, in_ad, in_bn, in_bd;
    logic         in_nan;

    logic         mul_start, div_start, gcd_start;
    logic [W-1:0] mul_a, mul_b, div_v, gcd_x, gcd_y;
    logic         mul_done, div_done, gcd_done;
    logic [W-1:0] mul_p, div_q, gcd_g;
    logic         is_cmp;

    assign in_cmd = s_tdata[2:0];
    assign in_an  = s_tdata[66:3];
    assign in_ad  = s_tdata[130:67];
    assign in_bn  = s_tdata[194:131];
    assign in_bd  = s_tdata[258:195];
    assign is_cmp = (cmd_reg == rau_pkg::CMD_CMP);

    always_comb begin
        case (in_cmd)
            rau_pkg::CMD_ADD, rau_pkg::CMD_SUB, rau_pkg::CMD_MUL, rau_pkg::CMD_CMP:
                in_nan = (in_ad == '0) || (in_bd == '0);
            rau_pkg::CMD_DIV:
                in_nan = (in_ad == '0) || (in_bd == '0) || (in_bn == '0);
            rau_pkg::CMD_RECIP, rau_pkg::CMD_SIMP:
                in_nan = (in_ad == '0);
            default:
                in_nan = 1'b1;
        endcase
    end

    // unit operand selection
    always_comb begin
        mul_start = 1'b0;
        div_start = 1'b0;
        gcd_start = 1'b0;
        mul_a     = rn_reg;
        mul_b     = sd_reg;
        div_v     = rn_reg;
        gcd_x     = rau_pkg::mag_of(tn_reg);
        gcd_y     = rau_pkg::mag_of(td_reg);
        case (cmd.op)
            rau_pkg::OP_MUL_RN_SD: begin mul_start = 1'b1; end
            rau_pkg::OP_MUL_SN_RD: begin mul_start = 1'b1; mul_a = sn_reg; mul_b = rd_reg; end
            rau_pkg::OP_MUL_RD_SD: begin mul_start = 1'b1; mul_a = rd_reg; end
            rau_pkg::OP_MUL_RN_SN: begin mul_start = 1'b1; mul_b = sn_reg; end
            rau_pkg::OP_DIV_RN: begin div_start = 1'b1; end
            rau_pkg::OP_DIV_SD: begin div_start = 1'b1; div_v = sd_reg; end
            rau_pkg::OP_DIV_RD: begin div_start = 1'b1; div_v = rd_reg; end
            rau_pkg::OP_DIV_SN: begin div_start = 1'b1; div_v = sn_reg; end
            rau_pkg::OP_DIV_TN: begin div_start = 1'b1; div_v = tn_reg; end
            rau_pkg::OP_DIV_TD: begin div_start = 1'b1; div_v = td_reg; end
            rau_pkg::OP_GCD_X1: begin
                gcd_start = 1'b1;
                gcd_x     = rau_pkg::mag_of(rn_reg);
                gcd_y     = rau_pkg::mag_of(sd_reg);
            end
            rau_pkg::OP_GCD_X2: begin
                gcd_start = 1'b1;
                gcd_x     = rau_pkg::mag_of(rd_reg);
                gcd_y     = rau_pkg::mag_of(sn_reg);
            end
            rau_pkg::OP_GCD_T: begin gcd_start = 1'b1; end
            default: begin end
        endcase
    end

    rau_mul u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start),
        .op_a(mul_a), .op_b(mul_b), .done(mul_done), .prod(mul_p)
    );

    rau_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .value(div_v), .divisor(g_reg), .done(div_done), .quot(div_q)
    );

    rau_gcd u_gcd (
        .aclk(aclk), .aresetn(aresetn), .start(gcd_start),
        .mag_x(gcd_x), .mag_y(gcd_y), .done(gcd_done), .gcd(gcd_g)
    );

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            cur_op_reg    <= rau_pkg::OP_NONE;
        end else begin
            // ops without a unit finish at once, units report their own done
            done_reg <= mul_done || div_done || gcd_done
                        || (cmd.op inside {rau_pkg::OP_MKPOS, rau_pkg::OP_SUM,
                                           rau_pkg::OP_DIFF, rau_pkg::OP_POS_T,
                                           rau_pkg::OP_NAN});
            if (cmd.op != rau_pkg::OP_NONE) begin
                cur_op_reg <= cmd.op;
            end
            if (cmd.op == rau_pkg::OP_EMIT) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        case (cmd.op)
            rau_pkg::OP_LOAD: begin
                cmd_reg <= in_cmd;
                nan_reg <= in_nan;
                cmp_reg <= {{(W-1){1'b0}}, 1'b1};
                rn_reg  <= in_an;
                rd_reg  <= in_ad;
                if (in_cmd == rau_pkg::CMD_DIV) begin
                    sn_reg <= in_bn[W-1] ? ('0 - in_bd) : in_bd;
                    sd_reg <= in_bn[W-1] ? ('0 - in_bn) : in_bn;
                end else begin
                    sn_reg <= (in_cmd == rau_pkg::CMD_SUB) ? ('0 - in_bn) : in_bn;
                    sd_reg <= in_bd;
                end
                if (in_cmd == rau_pkg::CMD_RECIP) begin
                    tn_reg <= in_an[W-1] ? ('0 - in_ad) : in_ad;
                    td_reg <= in_an[W-1] ? ('0 - in_an) : in_an;
                end else begin
                    tn_reg <= in_an;
                    td_reg <= in_ad;
                end
            end
            rau_pkg::OP_MKPOS: begin
                if (rd_reg[W-1]) begin
                    rn_reg <= '0 - rn_reg;
                    rd_reg <= '0 - rd_reg;
                end
                if (sd_reg[W-1]) begin
                    sn_reg <= '0 - sn_reg;
                    sd_reg <= '0 - sd_reg;
                end
            end
            rau_pkg::OP_POS_T: begin
                if (td_reg[W-1]) begin
                    tn_reg <= '0 - tn_reg;
                    td_reg <= '0 - td_reg;
                end
            end
            rau_pkg::OP_SUM:  tn_reg  <= tn_reg + pb_reg;
            rau_pkg::OP_DIFF: cmp_reg <= tn_reg - pb_reg;
            rau_pkg::OP_NAN: begin
                tn_reg <= '0;
                td_reg <= '0;
            end
            rau_pkg::OP_EMIT: begin
                out_n_reg   <= (is_cmp || td_reg == '0) ? '0 : tn_reg;
                out_d_reg   <= is_cmp ? '0 : td_reg;
                out_c_reg   <= is_cmp ? cmp_reg : '0;
                out_nan_reg <= is_cmp ? nan_reg : (td_reg == '0);
            end
            default: begin end
        endcase

        if (gcd_done) begin
            g_reg <= gcd_g;
        end
        if (mul_done) begin
            case (cur_op_reg)
                rau_pkg::OP_MUL_SN_RD: pb_reg <= mul_p;
                rau_pkg::OP_MUL_RD_SD: td_reg <= mul_p;
                default:               tn_reg <= mul_p;
            endcase
        end
        if (div_done) begin
            case (cur_op_reg)
                rau_pkg::OP_DIV_RN: rn_reg <= div_q;
                rau_pkg::OP_DIV_SD: sd_reg <= div_q;
                rau_pkg::OP_DIV_RD: rd_reg <= div_q;
                rau_pkg::OP_DIV_SN: sn_reg <= div_q;
                rau_pkg::OP_DIV_TN: tn_reg <= div_q;
                default:            td_reg <= div_q;
            endcase
        end
    end

    assign stat.done     = done_reg;
    assign stat.nan_in   = nan_reg;
    assign stat.td_zero  = (td_reg == '0);
    assign stat.out_free = !out_valid_reg || m_tready;
    assign stat.cmd      = cmd_reg;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_c_reg, out_d_reg, out_n_reg};
    assign m_tuser  = out_nan_reg;

endmodule

`default_nettype wire

// ===== rtl/core/rau_ctrl.sv =====
// ----------------------------------------------------------------------------
// rau_ctrl
// command sequencer: issues datapath ops and waits for completion
// ----------------------------------------------------------------------------
`default_nettype none

`include "rational_arithmetic_unit_macros.svh"

module rau_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    output rau_pkg::dp_cmd_t       cmd,
    input  wire rau_pkg::dp_stat_t stat
);

    rau_pkg::ctrl_state_t state_reg, state_next;
    logic                 wait_reg, wait_next;
    logic                 in_beat;

    function automatic rau_pkg::dp_op_t step_op(input rau_pkg::ctrl_state_t st);
        case (st)
            rau_pkg::ST_MKPOS:     return rau_pkg::OP_MKPOS;
            rau_pkg::ST_GCD_X1:    return rau_pkg::OP_GCD_X1;
            rau_pkg::ST_DIV_RN:    return rau_pkg::OP_DIV_RN;
            rau_pkg::ST_DIV_SD:    return rau_pkg::OP_DIV_SD;
            rau_pkg::ST_GCD_X2:    return rau_pkg::OP_GCD_X2;
            rau_pkg::ST_DIV_RD:    return rau_pkg::OP_DIV_RD;
            rau_pkg::ST_DIV_SN:    return rau_pkg::OP_DIV_SN;
            rau_pkg::ST_MUL_RN_SN: return rau_pkg::OP_MUL_RN_SN;
            rau_pkg::ST_MUL_RD_SD: return rau_pkg::OP_MUL_RD_SD;
            rau_pkg::ST_MUL_RN_SD: return rau_pkg::OP_MUL_RN_SD;
            rau_pkg::ST_MUL_SN_RD: return rau_pkg::OP_MUL_SN_RD;
            rau_pkg::ST_SUM:       return rau_pkg::OP_SUM;
            rau_pkg::ST_DIFF:      return rau_pkg::OP_DIFF;
            rau_pkg::ST_POS_T:     return rau_pkg::OP_POS_T;
            rau_pkg::ST_GCD_T:     return rau_pkg::OP_GCD_T;
            rau_pkg::ST_DIV_TN:    return rau_pkg::OP_DIV_TN;
            rau_pkg::ST_DIV_TD:    return rau_pkg::OP_DIV_TD;
            rau_pkg::ST_NAN:       return rau_pkg::OP_NAN;
            default:               return rau_pkg::OP_NONE;
        endcase
    endfunction

    function automatic rau_pkg::ctrl_state_t step_after(input rau_pkg::ctrl_state_t st,
                                                        input logic [rau_pkg::CMD_W-1:0] c);
        logic add_like;
        add_like = (c inside {rau_pkg::CMD_ADD, rau_pkg::CMD_SUB});
        case (st)
            rau_pkg::ST_MKPOS:     return add_like ? rau_pkg::ST_MUL_RN_SD : rau_pkg::ST_GCD_X1;
            rau_pkg::ST_GCD_X1:    return rau_pkg::ST_DIV_RN;
            rau_pkg::ST_DIV_RN:    return rau_pkg::ST_DIV_SD;
            rau_pkg::ST_DIV_SD:    return rau_pkg::ST_GCD_X2;
            rau_pkg::ST_GCD_X2:    return rau_pkg::ST_DIV_RD;
            rau_pkg::ST_DIV_RD:    return rau_pkg::ST_DIV_SN;
            rau_pkg::ST_DIV_SN:    return rau_pkg::ST_MUL_RN_SN;
            rau_pkg::ST_MUL_RN_SN: return rau_pkg::ST_MUL_RD_SD;
            rau_pkg::ST_MUL_RD_SD: return add_like ? rau_pkg::ST_SUM : rau_pkg::ST_CHECK;
            rau_pkg::ST_MUL_RN_SD: return rau_pkg::ST_MUL_SN_RD;
            rau_pkg::ST_MUL_SN_RD: begin
                return (c == rau_pkg::CMD_CMP) ? rau_pkg::ST_DIFF : rau_pkg::ST_MUL_RD_SD;
            end
            rau_pkg::ST_SUM:       return rau_pkg::ST_CHECK;
            rau_pkg::ST_DIFF:      return rau_pkg::ST_EMIT;
            rau_pkg::ST_POS_T:     return rau_pkg::ST_GCD_T;
            rau_pkg::ST_GCD_T:     return rau_pkg::ST_DIV_TN;
            rau_pkg::ST_DIV_TN:    return rau_pkg::ST_DIV_TD;
            rau_pkg::ST_DIV_TD:    return rau_pkg::ST_EMIT;
            rau_pkg::ST_NAN:       return rau_pkg::ST_EMIT;
            default:               return rau_pkg::ST_IDLE;
        endcase
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rau_pkg::ST_IDLE;
            wait_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            wait_reg  <= wait_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        wait_next  = wait_reg;
        cmd.op     = rau_pkg::OP_NONE;
        s_tready   = 1'b0;
        case (state_reg)
            rau_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.op     = rau_pkg::OP_LOAD;
                    state_next = rau_pkg::ST_DISPATCH;
                end
            end
            rau_pkg::ST_DISPATCH: begin
                if (stat.nan_in) begin
                    state_next = (stat.cmd == rau_pkg::CMD_CMP) ? rau_pkg::ST_EMIT
                                                                : rau_pkg::ST_NAN;
                end else if (stat.cmd inside {rau_pkg::CMD_ADD, rau_pkg::CMD_SUB,
                                              rau_pkg::CMD_MUL, rau_pkg::CMD_DIV}) begin
                    state_next = rau_pkg::ST_MKPOS;
                end else if (stat.cmd == rau_pkg::CMD_CMP) begin
                    state_next = rau_pkg::ST_MUL_RN_SD;
                end else if (stat.cmd == rau_pkg::CMD_SIMP) begin
                    state_next = rau_pkg::ST_CHECK;
                end else begin
                    state_next = rau_pkg::ST_EMIT;
                end
            end
            rau_pkg::ST_CHECK: begin
                state_next = stat.td_zero ? rau_pkg::ST_NAN : rau_pkg::ST_POS_T;
            end
            rau_pkg::ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.op     = rau_pkg::OP_EMIT;
                    state_next = rau_pkg::ST_IDLE;
                end
            end
            default: begin
                if (!wait_reg) begin
                    cmd.op    = step_op(state_reg);
                    wait_next = 1'b1;
                end else if (stat.done) begin
                    wait_next  = 1'b0;
                    state_next = step_after(state_reg, stat.cmd);
                end
            end
        endcase
    end

    assign in_beat = s_tvalid && s_tready;

    `RAU_ASSERT_SAME(a_done_only_when_waiting, aclk, aresetn, stat.done, wait_reg)
    `RAU_ASSERT_NEXT(a_accept_to_dispatch, aclk, aresetn, in_beat, state_reg == rau_pkg::ST_DISPATCH)
    `RAU_ASSERT_SAME(a_emit_needs_slot, aclk, aresetn, cmd.op == rau_pkg::OP_EMIT, stat.out_free)

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// rational arithmetic unit testbench
// drives fraction commands over the input stream, predicts each result with a
// behavioral fraction model and compares every result beat field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module testbench;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [rau_pkg::CMD_W-1:0] CMD_UNUSED = 3'd7;

    typedef logic [rau_pkg::DATA_W-1:0] word_t;

    typedef struct packed {
        word_t num;
        word_t den;
    } frac_t;

    typedef struct packed {
        word_t num;
        word_t den;
        word_t cmp;
        logic  nan;
    } fresult_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic [rau_pkg::S_TDATA_W-1:0]  s_tdata = '0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [rau_pkg::M_TDATA_W-1:0]  m_tdata;
    logic [0:0]                     m_tuser;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;

    fresult_t expected_q[$];
    int       errors = 0;
    int       idle_cycles = 0;
    bit       hold_off = 1'b0;
    bit       sender_bursty = 1'b1;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    rational_arithmetic_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    // ------------------------------------------------------------------
    // fraction model
    // ------------------------------------------------------------------
    function automatic bit is_neg(word_t v);
        return v[rau_pkg::DATA_W-1];
    endfunction

    function automatic word_t magnitude(word_t v);
        return is_neg(v) ? -v : v;
    endfunction

    function automatic word_t euclid_gcd(word_t x, word_t y);
        word_t t;
        while (y != 0) begin
            t = y;
            y = x % y;
            x = t;
        end
        return x;
    endfunction

    // truncating signed divide by a nonzero magnitude
    function automatic word_t div_by_mag(word_t v, word_t g);
        word_t q;
        q = magnitude(v) / g;
        return is_neg(v) ? -q : q;
    endfunction

    function automatic frac_t nan_frac();
        frac_t z;
        z.num = '0;
        z.den = '0;
        return z;
    endfunction

    function automatic frac_t positive_den(frac_t r);
        if (is_neg(r.den)) begin
            r.num = -r.num;
            r.den = -r.den;
        end
        return r;
    endfunction

    function automatic frac_t reduce_frac(frac_t r);
        word_t g;
        if (r.den == 0) return nan_frac();
        r = positive_den(r);
        g = euclid_gcd(magnitude(r.num), magnitude(r.den));
        r.num = div_by_mag(r.num, g);
        r.den = div_by_mag(r.den, g);
        return r;
    endfunction

    function automatic frac_t frac_sum(frac_t r, frac_t s);
        frac_t t;
        if (r.den == 0 || s.den == 0) return nan_frac();
        r = positive_den(r);
        s = positive_den(s);
        t.num = r.num * s.den + s.num * r.den;
        t.den = r.den * s.den;
        return reduce_frac(t);
    endfunction

    function automatic frac_t frac_product(frac_t r, frac_t s);
        word_t g;
        if (r.den == 0 || s.den == 0) return nan_frac();
        r = positive_den(r);
        s = positive_den(s);
        g = euclid_gcd(magnitude(r.num), magnitude(s.den));
        r.num = div_by_mag(r.num, g);
        s.den = div_by_mag(s.den, g);
        g = euclid_gcd(magnitude(r.den), magnitude(s.num));
        r.den = div_by_mag(r.den, g);
        s.num = div_by_mag(s.num, g);
        r.num = r.num * s.num;
        r.den = r.den * s.den;
        return reduce_frac(r);
    endfunction

    function automatic frac_t frac_inverse(frac_t r);
        frac_t t;
        if (r.den == 0) return nan_frac();
        if (is_neg(r.num)) begin
            t.num = -r.den;
            t.den = -r.num;
        end else begin
            t.num = r.den;
            t.den = r.num;
        end
        return t;
    endfunction

    function automatic fresult_t predict_fraction(logic [rau_pkg::CMD_W-1:0] cmd,
                                                  frac_t a, frac_t b);
        fresult_t o;
        frac_t    res;
        o = '0;
        res = nan_frac();
        case (cmd)
            rau_pkg::CMD_ADD: res = frac_sum(a, b);
            rau_pkg::CMD_SUB: begin
                b.num = -b.num;
                res = frac_sum(a, b);
            end
            rau_pkg::CMD_MUL: res = frac_product(a, b);
            rau_pkg::CMD_DIV: begin
                res = (b.den == 0) ? nan_frac() : frac_product(a, frac_inverse(b));
            end
            rau_pkg::CMD_CMP: begin
                if (a.den == 0 || b.den == 0) begin
                    o.cmp = word_t'(1);
                    o.nan = 1'b1;
                end else begin
                    o.cmp = a.num * b.den - b.num * a.den;
                end
                return o;
            end
            rau_pkg::CMD_RECIP: res = frac_inverse(a);
            rau_pkg::CMD_SIMP:  res = reduce_frac(a);
            default:            res = nan_frac();
        endcase
        if (res.den == 0) res.num = '0;
        o.num = res.num;
        o.den = res.den;
        o.nan = (res.den == 0);
        return o;
    endfunction

    // ------------------------------------------------------------------
    // sender: one beat per call, bursty gaps before it
    // ------------------------------------------------------------------
    task automatic send_fraction_op(logic [rau_pkg::CMD_W-1:0] cmd, word_t an, word_t ad,
                                    word_t bn, word_t bd);
        int gap;
        gap = 0;
        if (sender_bursty && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 12);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= {5'b0, bd, bn, ad, an, cmd};
        s_tvalid <= 1'b1;
        expected_q.push_back(predict_fraction(cmd, '{an, ad}, '{bn, bd}));
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // drop valid after the last beat of a run
    task automatic release_input();
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_results_drained();
        while (expected_q.size() != 0) @(posedge aclk);
    endtask

    function automatic word_t rand_word();
        return {$urandom(), $urandom()};
    endfunction

    // mostly small operands so products rarely wrap, some full width
    function automatic word_t rand_operand();
        case ($urandom_range(0, 7))
            0:       return rand_word();
            1:       return {$urandom(), 32'b0} >>> $urandom_range(0, 40);
            2:       return word_t'(64'sh8000_0000_0000_0000);
            3:       return -word_t'($urandom_range(0, 1000));
            default: return word_t'($urandom_range(0, 2000)) - 1000;
        endcase
    endfunction

    function automatic word_t rand_den();
        if ($urandom_range(0, 15) == 0) return '0;
        return rand_operand();
    endfunction

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, word_t got, word_t want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge aclk) begin
        fresult_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected beat", m_tdata[63:0], '0);
            end else begin
                want = expected_q.pop_front();
                if (m_tdata[63:0] !== want.num)
                    report_mismatch("result_numerator", m_tdata[63:0], want.num);
                if (m_tdata[127:64] !== want.den)
                    report_mismatch("result_denominator", m_tdata[127:64], want.den);
                if (m_tdata[191:128] !== want.cmp)
                    report_mismatch("compare_value", m_tdata[191:128], want.cmp);
                if (m_tuser[0] !== want.nan)
                    report_mismatch("is_nan", word_t'(m_tuser[0]), word_t'(want.nan));
            end
        end
    end

    // receiver stalls on its own pattern; hold_off forces a long stretch
    always @(posedge aclk) begin
        logic [3:0] pat;
        pat = 4'($urandom());
        if (hold_off) m_tready <= 1'b0;
        else          m_tready <= (pat != 4'd0 && pat != 4'd1) || !sender_bursty;
    end

    // watchdog on cycles with no accepted beat
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    localparam word_t MIN_W = 64'h8000_0000_0000_0000;
    localparam word_t MAX_W = 64'h7fff_ffff_ffff_ffff;
    localparam word_t ONES  = 64'hffff_ffff_ffff_ffff;

    task automatic test_directed();
        // every command on plain values
        send_fraction_op(rau_pkg::CMD_ADD, 1, 2, 1, 3);
        send_fraction_op(rau_pkg::CMD_SUB, 1, 2, 3, -4);
        send_fraction_op(rau_pkg::CMD_MUL, 6, 35, 14, 15);
        send_fraction_op(rau_pkg::CMD_DIV, -3, 4, 9, -8);
        send_fraction_op(rau_pkg::CMD_CMP, 1, 3, 1, 2);
        send_fraction_op(rau_pkg::CMD_RECIP, -5, 7, 0, 1);
        send_fraction_op(rau_pkg::CMD_SIMP, 12, -18, 0, 1);
        send_fraction_op(CMD_UNUSED, 1, 1, 1, 1);
        // nan operands and divide by zero
        send_fraction_op(rau_pkg::CMD_ADD, 4, 0, 1, 1);
        send_fraction_op(rau_pkg::CMD_MUL, 1, 1, 5, 0);
        send_fraction_op(rau_pkg::CMD_CMP, 2, 0, 1, 1);
        send_fraction_op(rau_pkg::CMD_DIV, 3, 5, 0, 7);
        send_fraction_op(rau_pkg::CMD_DIV, 3, 5, 2, 0);
        // reciprocal of zero gives nan
        send_fraction_op(rau_pkg::CMD_RECIP, 0, 9, 0, 1);
        // most negative denominator stays negative
        send_fraction_op(rau_pkg::CMD_SIMP, 4, MIN_W, 0, 1);
        send_fraction_op(rau_pkg::CMD_ADD, MIN_W, MIN_W, MAX_W, MIN_W);
        // wrapped product that is zero
        send_fraction_op(rau_pkg::CMD_MUL, 64'h1_0000_0000, 1, 64'h1_0000_0000, 1);
        send_fraction_op(rau_pkg::CMD_MUL, 1, 64'h1_0000_0000, 1, 64'h1_0000_0000);
        // full-width extremes
        send_fraction_op(rau_pkg::CMD_CMP, MAX_W, ONES, MIN_W, MAX_W);
        send_fraction_op(rau_pkg::CMD_SUB, ONES, MAX_W, MIN_W, ONES);
        send_fraction_op(rau_pkg::CMD_RECIP, MIN_W, MAX_W, 0, 1);
        send_fraction_op(rau_pkg::CMD_SIMP, 0, -7, 0, 1);
        release_input();
        wait_results_drained();
    endtask

    task automatic test_random(int count);
        logic [rau_pkg::CMD_W-1:0] cmd;
        repeat (count) begin
            cmd = rau_pkg::CMD_W'($urandom_range(0, 7));
            send_fraction_op(cmd, rand_operand(), rand_den(), rand_operand(), rand_den());
        end
        release_input();
    endtask

    // receiver holds off while the sender keeps offering beats
    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (3000) @(posedge aclk);
                hold_off = 1'b0;
            end
            test_random(8);
        join
        wait_results_drained();
    endtask

    // no gaps and no stalls back to back
    task automatic test_streaming();
        sender_bursty = 1'b0;
        test_random(100);
        sender_bursty = 1'b1;
        wait_results_drained();
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_backpressure();
        test_streaming();
        test_random(1400);
        wait_results_drained();
        repeat (1000) @(posedge aclk);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/rau_pkg.sv
rtl/core/rau_mul.sv
rtl/core/rau_div.sv
rtl/core/rau_gcd.sv
rtl/core/rau_datapath.sv
rtl/core/rau_ctrl.sv
rtl/core/rational_arithmetic_unit.sv
tb/testbench.sv
